@@ rtl/plt_pkg.sv @@
package plt_pkg;

    // field widths
    localparam int TEMP_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int POINT_W    = 32;
    localparam int PIU_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register map: point registers first, then the point count
    localparam int                   NUM_POINT_REGS    = 7;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_IN_USE = 3'd7;
    localparam logic [PIU_W-1:0]     POINTS_IN_USE_RST = 3'd7;

    // breakpoint reset values, x in the upper half, y in the lower half
    localparam logic [POINT_W-1:0] POINT_RESET [NUM_POINT_REGS] = '{
        32'd491520100, 32'd655360085, 32'd819200078, 32'd1310720062,
        32'd1966080046, 32'd2293760040, 32'd4294901765
    };

    // job queue depth
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one classified item: either a finished value or a segment to interpolate
    typedef struct packed {
        logic                    interp;
        logic [TEMP_W-1:0]       value;   // final result, or y0 of the segment
        logic signed [TEMP_W:0]  dy;      // y1 - y0
        logic [SAMPLE_W-1:0]     off;     // sample - x0
        logic [SAMPLE_W-1:0]     dx;      // x1 - x0, always nonzero
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/plt_if.sv @@
interface plt_in_if;
    logic                          valid;
    logic                          ready;
    logic [plt_pkg::SAMPLE_W-1:0]  raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface plt_out_if;
    logic                        valid;
    logic                        ready;
    logic [plt_pkg::TEMP_W-1:0]  temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

@@ rtl/plt_front.sv @@
module plt_front #(
    parameter int MAX_POINTS = 7
) (
    plt_in_if.sink                       i_sample,
    input  logic [plt_pkg::POINT_W-1:0]  i_points [MAX_POINTS],
    input  logic [plt_pkg::PIU_W-1:0]    i_points_in_use,
    input  plt_pkg::t_q_stat             i_q_stat,
    output logic                         o_push,
    output plt_pkg::t_job                o_job
);

    localparam logic [plt_pkg::PIU_W-1:0] MAX_N = plt_pkg::PIU_W'(MAX_POINTS);
    localparam logic [plt_pkg::PIU_W-1:0] TWO_N = plt_pkg::PIU_W'(2);

    logic [plt_pkg::PIU_W-1:0]     n;
    logic [plt_pkg::SAMPLE_W-1:0]  s;
    logic [plt_pkg::SAMPLE_W-1:0]  x_first, x_last, x0, x1;
    logic [plt_pkg::TEMP_W-1:0]    y_first, y_last, y0, y1;
    logic                          found;

    assign i_sample.ready = !i_q_stat.full;
    assign o_push         = i_sample.valid && !i_q_stat.full;

    always_comb begin
        n = (i_points_in_use > MAX_N) ? MAX_N : i_points_in_use;
        s = i_sample.raw_sample;

        x_first = i_points[0][31:16];
        y_first = i_points[0][15:0];

        x_last = '0;
        y_last = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (plt_pkg::PIU_W'(k + 1) == n) begin
                x_last = i_points[k][31:16];
                y_last = i_points[k][15:0];
            end
        end

        // first breakpoint above the sample; walking down leaves the lowest hit
        found = 1'b0;
        x0 = '0;
        x1 = '0;
        y0 = '0;
        y1 = '0;
        for (int i = MAX_POINTS - 1; i >= 1; i--) begin
            if (plt_pkg::PIU_W'(i) < n && s < i_points[i][31:16]) begin
                found = 1'b1;
                x0 = i_points[i-1][31:16];
                x1 = i_points[i][31:16];
                y0 = i_points[i-1][15:0];
                y1 = i_points[i][15:0];
            end
        end

        o_job = '0;
        if (n == '0) begin
            o_job.value = '0;
        end else if (s < x_first) begin
            o_job.value = y_first;
        end else if (s > x_last) begin
            o_job.value = y_last;
        end else if (n < TWO_N) begin
            o_job.value = '0;
        end else if (!found) begin
            o_job.value = y_last;
        end else begin
            o_job.interp = 1'b1;
            o_job.value  = y0;
            o_job.dy     = $signed({y1[15], y1}) - $signed({y0[15], y0});
            o_job.off    = s - x0;
            o_job.dx     = x1 - x0;
        end
    end

endmodule

@@ rtl/plt_queue.sv @@
module plt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  plt_pkg::t_job     i_job,
    input  logic              i_pop,
    output plt_pkg::t_job     o_job,
    output plt_pkg::t_q_stat  o_stat
);

    localparam logic [plt_pkg::Q_CNT_W-1:0] FULL_CNT = plt_pkg::Q_CNT_W'(plt_pkg::Q_DEPTH);

    plt_pkg::t_job                r_mem [plt_pkg::Q_DEPTH];
    logic [plt_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [plt_pkg::Q_CNT_W-1:0]  r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == FULL_CNT);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/plt_back.sv @@
module plt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plt_pkg::t_job     i_job,
    input  plt_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    plt_out_if.source         o_result
);

    localparam int W     = plt_pkg::TEMP_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_SUM, ST_ABS, ST_DIV, ST_DONE
    } t_state;

    t_state                    r_state;
    plt_pkg::t_job             r_job;
    logic signed [2*W+1:0]     r_prod, r_base;
    logic signed [2*W+2:0]     r_num;
    logic                      r_neg;
    logic [W-1:0]              r_rem, r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_out_valid;
    logic [W-1:0]              r_out_temp;

    logic                      out_free;
    logic                      load_out;
    logic signed [W:0]         mul_a, mul_b;
    logic signed [2*W+1:0]     mul_p;
    logic [2*W+2:0]            num_mag;
    logic [W:0]                trial, diff;
    logic                      ge;
    logic [W-1:0]              q_final;

    assign out_free = !r_out_valid || o_result.ready;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_stat.empty && out_free;

    // output register loads a finished value or a finished quotient
    assign load_out = (o_pop && !i_job.interp) || ((r_state == ST_DONE) && out_free);

    assign o_result.valid       = r_out_valid;
    assign o_result.temperature = r_out_temp;

    // one shared multiplier: y0 * dx first, then (s - x0) * (y1 - y0)
    always_comb begin
        if (r_state == ST_MUL_A) begin
            mul_a = $signed({r_job.value[W-1], r_job.value});
            mul_b = $signed({1'b0, r_job.dx});
        end else begin
            mul_a = $signed({1'b0, r_job.off});
            mul_b = r_job.dy;
        end
        mul_p = mul_a * mul_b;
    end

    // restoring divide step, one quotient bit per cycle
    always_comb begin
        num_mag = r_num[2*W+2] ? 35'(-r_num) : 35'(r_num);
        trial   = {r_rem, r_quo[W-1]};
        ge      = (trial >= {1'b0, r_job.dx});
        diff    = trial - {1'b0, r_job.dx};
        q_final = r_neg ? (W)'(-r_quo) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_job <= i_job;
                        if (i_job.interp) begin
                            r_state <= ST_MUL_A;
                        end else begin
                            r_out_temp <= i_job.value;
                        end
                    end
                end
                ST_MUL_A: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_base  <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_num   <= 35'(r_base) + 35'(r_prod);
                    r_state <= ST_ABS;
                end
                ST_ABS: begin
                    // |num| stays below dx * 2^16, so the upper half is below dx
                    r_neg   <= r_num[2*W+2];
                    r_rem   <= num_mag[2*W-1:W];
                    r_quo   <= num_mag[W-1:0];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_temp <= q_final;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/piecewise_linear_temperature_core.sv @@
// path: a clamped or trivial sample goes through the job queue into the output
//   register; a sample that needs interpolation also passes the multiply and divide steps
// throughput: one clamped item per cycle while the output is taken; the back end
//   takes no new job while an interpolated item runs the 16-step serial divider,
//   two multiply passes, the sum and sign steps and the output handoff
// reset: synchronous active-low i_rst_n, breakpoints and point count return
//   to their defaults, job queue and output stage empty
module piecewise_linear_temperature_core #(
    parameter int MAX_POINTS = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    plt_in_if.sink                            i_sample,
    plt_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [plt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [plt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // breakpoint registers; only the ones that can take part are kept
    logic [plt_pkg::POINT_W-1:0]  r_point [MAX_POINTS];
    logic [plt_pkg::PIU_W-1:0]    r_points_in_use;

    // front to queue
    logic                         push;
    plt_pkg::t_job                job_in;

    // queue to back
    logic                         pop;
    plt_pkg::t_job                job_out;
    plt_pkg::t_q_stat             q_stat;

    // configuration writes; indexes past the kept points fall away
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_point[k] <= plt_pkg::POINT_RESET[k];
            end
            r_points_in_use <= plt_pkg::POINTS_IN_USE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == plt_pkg::REG_POINTS_IN_USE) begin
                r_points_in_use <= i_cfg_data[plt_pkg::PIU_W-1:0];
            end
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (i_cfg_idx == plt_pkg::CFG_IDX_W'(k)) begin
                    r_point[k] <= i_cfg_data[plt_pkg::POINT_W-1:0];
                end
            end
        end
    end

    // front: takes a sample, clamps to the table ends or picks the segment
    // and hands a job to the queue; it stalls only when the queue is full
    plt_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_sample        (i_sample),
        .i_points        (r_point),
        .i_points_in_use (r_points_in_use),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_job           (job_in)
    );

    // short job queue so sampling and the divider stall independently
    plt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    // back: finished values go straight to the output register, segments
    // go through two multiply passes and a restoring divide with
    // truncation toward zero
    plt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_result (o_result)
    );

    // the back end only takes a job that is really there
    a_pop_has_job: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) pop |-> !q_stat.empty
    ) else $error("job taken from empty queue");

    // the front end never writes over a queued job
    a_push_has_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) push |-> !q_stat.full
    ) else $error("job written into full queue");

    // taking a job always leaves room behind it
    a_pop_frees_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) pop |=> !q_stat.full
    ) else $error("queue full right after a job was taken");

endmodule
